[hdl/accel_tilt_angle_with_calibration_macros.svh]
// Assertion macros for the tilt angle block.
`ifndef ACCEL_TILT_ANGLE_WITH_CALIBRATION_MACROS_SVH
`define ACCEL_TILT_ANGLE_WITH_CALIBRATION_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ATA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define ATA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hdl/ata_pkg.sv]
// Shared types and constants for the tilt angle block.
package ata_pkg;
  localparam int unsigned RawW = 16;
  localparam int unsigned OffW = 18;
  localparam int unsigned DifW = 19;
  localparam int unsigned SqW = 38;
  localparam int unsigned RootW = 27;
  localparam int unsigned CorW = 32;
  localparam int unsigned AngW = 30;
  localparam int unsigned SumW = 28;
  localparam logic signed [15:0] AngMax = 16'sd23040;
  localparam logic CMD_CALIB = 1'b0;
  localparam logic CMD_MEAS = 1'b1;

  typedef struct packed {
    logic load;
    logic sq_start;
    logic sq_step;
    logic cor_init;
    logic cor_step;
    logic sel_pitch;
    logic save_roll;
    logic save_pitch;
  } ctl_t;

  typedef struct packed {
    logic sq_last;
    logic cor_last;
  } sts_t;

  function automatic logic [AngW-1:0] atan_lut(input logic [4:0] i);
    logic [AngW-1:0] v;
    case (i)
      5'd0: v = 30'd2949120;  5'd1: v = 30'd1740967;  5'd2: v = 30'd919879;
      5'd3: v = 30'd466945;   5'd4: v = 30'd234379;   5'd5: v = 30'd117304;
      5'd6: v = 30'd58666;    5'd7: v = 30'd29335;    5'd8: v = 30'd14668;
      5'd9: v = 30'd7334;     5'd10: v = 30'd3667;    5'd11: v = 30'd1833;
      5'd12: v = 30'd917;     5'd13: v = 30'd458;     5'd14: v = 30'd229;
      5'd15: v = 30'd115;     5'd16: v = 30'd57;      5'd17: v = 30'd29;
      5'd18: v = 30'd14;      5'd19: v = 30'd7;       5'd20: v = 30'd4;
      5'd21: v = 30'd2;       5'd22: v = 30'd1;       default: v = '0;
    endcase
    return v;
  endfunction
endpackage

[hdl/ata_if.sv]
// Valid/ready channel interface for the tilt angle block.
interface ata_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic signed [15:0] raw_x;
  logic signed [15:0] raw_y;
  logic signed [15:0] raw_z;
  modport source (output valid, cmd, raw_x, raw_y, raw_z, input ready);
  modport sink (input valid, cmd, raw_x, raw_y, raw_z, output ready);
endinterface

interface ata_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic angle_valid;
  logic calib_done;
  modport source (output valid, angle_x, angle_y, angle_valid, calib_done, input ready);
  modport sink (input valid, angle_x, angle_y, angle_valid, calib_done, output ready);
endinterface

interface ata_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[hdl/ata_datapath.sv]
// Datapath: difference, square root and CORDIC units for one angle at a time.
module ata_datapath
  import ata_pkg::*;
#(
  parameter int unsigned CORDIC_ITERS = 16
) (
  input  logic                     clk,
  input  ctl_t                     ctl,
  output sts_t                     sts,
  input  logic signed [RawW-1:0]   raw_x,
  input  logic signed [RawW-1:0]   raw_y,
  input  logic signed [RawW-1:0]   raw_z,
  input  logic signed [OffW-1:0]   off_x,
  input  logic signed [OffW-1:0]   off_y,
  input  logic signed [OffW-1:0]   off_z,
  output logic signed [15:0]       roll,
  output logic signed [15:0]       pitch
);
  logic signed [DifW-1:0] dx_r, dy_r, dz_r;
  logic [SqW+16-1:0] rem_r, rem_nxt;
  logic [RootW-1:0] root_r, root_nxt;
  logic [4:0] sq_i_r;
  logic signed [CorW-1:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic signed [AngW-1:0] cz_r, cz_nxt;
  logic [4:0] ci_r;
  logic zero_r;
  logic signed [15:0] roll_r, pitch_r;
  logic signed [DifW-1:0] na, nb, nn;
  logic signed [2*DifW-1:0] na2, nb2;
  logic [SqW-1:0] sq, sq_r;
  logic [SqW+16-1:0] rad;
  logic [SqW+16+1:0] trial;
  logic signed [AngW-1:0] zr;
  logic signed [15:0] ang;

  assign na = ctl.sel_pitch ? dy_r : dx_r;
  assign nn = ctl.sel_pitch ? dx_r : dy_r;
  assign nb = dz_r;
  assign na2 = na * na;
  assign nb2 = nb * nb;
  assign sq = SqW'(unsigned'(na2)) + SqW'(unsigned'(nb2));
  assign rad = {sq_r, 16'd0};

  // Restoring square root, two radicand bits per step, 27 steps.
  always_comb begin
    logic [1:0] pair;
    pair = rad[2*(26-sq_i_r) +: 2];
    trial = {rem_r[SqW+16-1:0], pair} - {root_r, 2'b01};
    if (!trial[SqW+16+1]) begin
      rem_nxt = trial[SqW+16-1:0];
      root_nxt = {root_r[RootW-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[SqW+16-3:0], pair};
      root_nxt = {root_r[RootW-2:0], 1'b0};
    end
  end

  always_comb begin
    logic signed [CorW-1:0] xs, ys;
    xs = cx_r >>> ci_r;
    ys = cy_r >>> ci_r;
    if (!cy_r[CorW-1]) begin
      cx_nxt = cx_r + ys;
      cy_nxt = cy_r - xs;
      cz_nxt = cz_r + AngW'(atan_lut(ci_r));
    end else begin
      cx_nxt = cx_r - ys;
      cy_nxt = cy_r + xs;
      cz_nxt = cz_r - AngW'(atan_lut(ci_r));
    end
  end

  assign zr = (cz_r + AngW'(128)) >>> 8;
  always_comb begin
    if (zero_r) ang = '0;
    else if (zr > AngW'(AngMax)) ang = AngMax;
    else if (zr < -AngW'(AngMax)) ang = -AngMax;
    else ang = zr[15:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dx_r <= DifW'(raw_x) - DifW'(off_x);
      dy_r <= DifW'(raw_y) - DifW'(off_y);
      dz_r <= DifW'(raw_z) - DifW'(off_z);
    end
    if (ctl.sq_start) begin
      sq_r <= sq;
      rem_r <= '0;
      root_r <= '0;
      sq_i_r <= '0;
    end else if (ctl.sq_step) begin
      rem_r <= rem_nxt;
      root_r <= root_nxt;
      sq_i_r <= sq_i_r + 5'd1;
    end
    if (ctl.cor_init) begin
      cx_r <= CorW'(root_r);
      cy_r <= CorW'(nn) <<< 8;
      cz_r <= '0;
      ci_r <= '0;
      zero_r <= (root_r == '0) && (nn == '0);
    end else if (ctl.cor_step) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      cz_r <= cz_nxt;
      ci_r <= ci_r + 5'd1;
    end
    if (ctl.save_roll) roll_r <= ang;
    if (ctl.save_pitch) pitch_r <= ang;
  end

  assign sts.sq_last = (sq_i_r == 5'd26);
  assign sts.cor_last = (ci_r == 5'(CORDIC_ITERS - 1));
  assign roll = roll_r;
  assign pitch = pitch_r;
endmodule

[hdl/ata_ctrl.sv]
// Controller: sequences calibration and the two angle computations.
module ata_ctrl
  import ata_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic in_cmd,
  input  logic out_fire,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy,
  output logic calib_step,
  output logic meas_done,
  output logic out_valid
);
  `include "accel_tilt_angle_with_calibration_macros.svh"
  typedef enum logic [2:0] {S_IDLE, S_SQ, S_CI, S_COR, S_SAVE, S_OUT} state_t;
  state_t state_r, state_nxt;
  logic pitch_r, pitch_nxt;
  logic ov_r, ov_nxt;

  always_comb begin
    state_nxt = state_r;
    pitch_nxt = pitch_r;
    ov_nxt = ov_r;
    ctl = '0;
    meas_done = 1'b0;
    calib_step = 1'b0;
    ctl.sel_pitch = pitch_r;
    if (out_fire) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_cmd == CMD_CALIB) begin
          calib_step = 1'b1;
          ov_nxt = 1'b1;
        end else if (in_fire) begin
          ctl.load = 1'b1;
          pitch_nxt = 1'b0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        ctl.sq_start = 1'b1;
        state_nxt = S_CI;
      end
      S_CI: begin
        ctl.sq_step = 1'b1;
        if (sts.sq_last) state_nxt = S_COR;
      end
      S_COR: begin
        state_nxt = S_SAVE;
        ctl.cor_init = 1'b1;
      end
      S_SAVE: begin
        ctl.cor_step = 1'b1;
        if (sts.cor_last) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!pitch_r) begin
          ctl.save_roll = 1'b1;
          pitch_nxt = 1'b1;
          state_nxt = S_SQ;
        end else begin
          ctl.save_pitch = 1'b1;
          meas_done = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pitch_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pitch_r <= pitch_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign busy = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;

  `ATA_ASSERT_IMP(a_no_accept_busy, clk, rst_n, in_fire, state_r == S_IDLE && !ov_r)
  `ATA_ASSERT_NEXT(a_meas_to_out, clk, rst_n, meas_done, ov_r && state_r == S_IDLE)
  `ATA_ASSERT_IMP(a_one_job, clk, rst_n, ov_r, state_r == S_IDLE)
endmodule

[hdl/accel_tilt_angle_with_calibration.sv]
// Top level of the accelerometer tilt angle block with offset calibration.
//   channel | dir | payload
//   in_     | in  | cmd, raw_x, raw_y, raw_z
//   out_    | out | angle_x, angle_y, angle_valid, calib_done
//   cfg_    | in  | data (accel_lsb_per_g)
// Calibration item: result valid in the cycle after it is accepted.
// Measurement item: computed by the shared bit-serial square root (27 steps)
// and the iterative CORDIC, run once per angle.
// One item at a time; the next is taken once the result has been taken.
// rst_n is synchronous, active low; it clears sums, count, offsets and flags.
module accel_tilt_angle_with_calibration
  import ata_pkg::*;
#(
  parameter int unsigned CALIB_LOG2 = 10,
  parameter int unsigned CORDIC_ITERS = 16
) (
  input logic clk,
  input logic rst_n,
  ata_in_if.sink in_ch,
  ata_out_if.source out_ch,
  ata_cfg_if.sink cfg_ch
);
  ctl_t ctl;
  sts_t sts;
  logic busy, calib_step, meas_done, out_valid;
  logic in_fire, out_fire;
  logic [15:0] lsb_r;
  logic signed [SumW-1:0] sx_r, sy_r, sz_r;
  logic [12:0] cnt_r;
  logic signed [OffW-1:0] ox_r, oy_r, oz_r;
  logic cdone_r, aval_r;
  logic signed [15:0] roll, pitch;
  logic signed [SumW-1:0] nsx, nsy, nsz, avz;
  logic [12:0] cnt_inc;

  assign in_ch.ready = !busy;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  ata_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .in_cmd(in_ch.cmd), .out_fire, .sts, .ctl,
    .busy, .calib_step, .meas_done, .out_valid
  );

  ata_datapath #(.CORDIC_ITERS(CORDIC_ITERS)) u_dp (
    .clk, .ctl, .sts, .raw_x(in_ch.raw_x), .raw_y(in_ch.raw_y), .raw_z(in_ch.raw_z),
    .off_x(ox_r), .off_y(oy_r), .off_z(oz_r), .roll, .pitch
  );

  // Restart the sums at the first calibration item of a run.
  assign nsx = (cnt_r == '0 ? '0 : sx_r) + SumW'(in_ch.raw_x);
  assign nsy = (cnt_r == '0 ? '0 : sy_r) + SumW'(in_ch.raw_y);
  assign nsz = (cnt_r == '0 ? '0 : sz_r) + SumW'(in_ch.raw_z);
  assign cnt_inc = cnt_r + 13'd1;
  assign avz = nsz >>> CALIB_LOG2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsb_r <= 16'd16384;
      sx_r <= '0; sy_r <= '0; sz_r <= '0;
      cnt_r <= '0;
      ox_r <= '0; oy_r <= '0; oz_r <= '0;
      cdone_r <= 1'b0;
      aval_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) lsb_r <= cfg_ch.data;
      if (calib_step) begin
        aval_r <= 1'b0;
        if (cnt_inc >= 13'(1 << CALIB_LOG2)) begin
          // Latch the floor averages, remove one g from Z.
          ox_r <= OffW'(nsx >>> CALIB_LOG2);
          oy_r <= OffW'(nsy >>> CALIB_LOG2);
          oz_r <= avz[SumW-1] ? OffW'(avz + SumW'(lsb_r)) : OffW'(avz - SumW'(lsb_r));
          cnt_r <= '0;
          sx_r <= '0; sy_r <= '0; sz_r <= '0;
          cdone_r <= 1'b1;
        end else begin
          cnt_r <= cnt_inc;
          sx_r <= nsx; sy_r <= nsy; sz_r <= nsz;
          cdone_r <= 1'b0;
        end
      end
      if (meas_done) begin
        aval_r <= 1'b1;
        cdone_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.angle_x = aval_r ? roll : '0;
  assign out_ch.angle_y = aval_r ? pitch : '0;
  assign out_ch.angle_valid = aval_r;
  assign out_ch.calib_done = cdone_r;
endmodule
